[src/lzwfc_pkg.sv]
// Shared constants and sequencer state type for the LZW fixed-code compressor.
`timescale 1ns / 1ps

package lzwfc_pkg;

    localparam int SYM_W      = 7;
    localparam int CODE_W     = 16;
    localparam int FIRST_CODE = 128;
    localparam int EPOCH_W    = 8;

    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b000_0001,
        ST_IDLE  = 7'b000_0010,
        ST_LOOK  = 7'b000_0100,
        ST_CMP   = 7'b000_1000,
        ST_EMIT  = 7'b001_0000,
        ST_FLUSH = 7'b010_0000,
        ST_TERM  = 7'b100_0000
    } t_state;

endpackage

[src/lzw_fixed_code_compressor.sv]
// Top level of the LZW compressor with hashed pair table and fixed-width codes.
//
//   channel  | handshake          | word
//   ---------+--------------------+------------------------
//   input    | i_valid / o_ready  | i_symbol, i_last
//   output   | o_valid / i_ready  | o_code, o_last_code
//
// The first symbol of a stream is only taken as the prefix. Every other symbol passes
// through hash, table read and compare, plus a table read and compare per extra linear
// probe of the single-port table. A miss adds an emit step; a last symbol adds two more
// (prefix and terminator). Each emit waits while the output register holds an untaken word.
// After reset, and after every 255 streams, a clearing pass sweeps all 2^(CODE_BITS+1)
// table slots while o_ready stays low.
`timescale 1ns / 1ps

module lzw_fixed_code_compressor #(
    parameter int CODE_BITS = 16,
    parameter int DICT_SIZE = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [lzwfc_pkg::SYM_W-1:0]      i_symbol,
    input  logic                             i_last,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [lzwfc_pkg::CODE_W-1:0]     o_code,
    output logic                             o_last_code
);

    localparam int HASH_BITS  = CODE_BITS + 1;
    localparam int KEY_W      = CODE_BITS + lzwfc_pkg::SYM_W;
    localparam int NEXT_W     = CODE_BITS + 1;
    localparam int CODE_LIMIT = (DICT_SIZE < (1 << CODE_BITS)) ? DICT_SIZE : (1 << CODE_BITS);
    localparam int SLOTS      = 1 << HASH_BITS;

    localparam logic [NEXT_W-1:0] LIMIT_N = NEXT_W'(CODE_LIMIT);
    localparam logic [NEXT_W-1:0] FIRST_N = NEXT_W'(lzwfc_pkg::FIRST_CODE);

    typedef struct packed {
        logic [lzwfc_pkg::EPOCH_W-1:0] gen;
        logic [KEY_W-1:0]              key;
        logic [CODE_BITS-1:0]          code;
    } t_slot;

    lzwfc_pkg::t_state r_state, n_state;

    logic [HASH_BITS-1:0]          r_clr_addr, n_clr_addr;
    logic [lzwfc_pkg::EPOCH_W-1:0] r_cur_gen, n_cur_gen;
    logic [NEXT_W-1:0]             r_next_code, n_next_code;
    logic                          r_prefix_valid, n_prefix_valid;
    logic [CODE_BITS-1:0]          r_prefix, n_prefix;
    logic [lzwfc_pkg::SYM_W-1:0]   r_sym, n_sym;
    logic                          r_last, n_last;
    logic [HASH_BITS-1:0]          r_slot, n_slot;
    logic                          r_o_valid, n_o_valid;
    logic [lzwfc_pkg::CODE_W-1:0]  r_o_code, n_o_code;
    logic                          r_o_last, n_o_last;

    t_slot                         mem [SLOTS];
    t_slot                         r_rd;

    logic                          w_we;
    logic [HASH_BITS-1:0]          w_addr;
    t_slot                         w_wdata;
    logic                          w_out_free;
    logic [31:0]                   w_key_in;
    logic [31:0]                   w_prod;
    logic [KEY_W-1:0]              w_key;
    logic                          w_live;
    logic                          w_hit;

    assign o_ready     = (r_state == lzwfc_pkg::ST_IDLE);
    assign o_valid     = r_o_valid;
    assign o_code      = r_o_code;
    assign o_last_code = r_o_last;

    assign w_out_free = !r_o_valid || i_ready;
    assign w_key_in   = 32'({r_prefix, i_symbol});
    assign w_prod     = w_key_in * lzwfc_pkg::HASH_MULT;
    assign w_key      = {r_prefix, r_sym};
    assign w_live     = (r_rd.gen == r_cur_gen);
    assign w_hit      = w_live && (r_rd.key == w_key);

    always_comb begin
        n_state        = r_state;
        n_clr_addr     = r_clr_addr;
        n_cur_gen      = r_cur_gen;
        n_next_code    = r_next_code;
        n_prefix_valid = r_prefix_valid;
        n_prefix       = r_prefix;
        n_sym          = r_sym;
        n_last         = r_last;
        n_slot         = r_slot;
        n_o_valid      = r_o_valid && !i_ready;
        n_o_code       = r_o_code;
        n_o_last       = r_o_last;
        w_we           = 1'b0;
        w_addr         = r_slot;
        w_wdata        = '0;
        case (r_state)
            lzwfc_pkg::ST_CLEAR: begin
                w_addr     = r_clr_addr;
                w_we       = 1'b1;
                n_clr_addr = r_clr_addr + HASH_BITS'(1);
                if (r_clr_addr == '1) begin
                    n_state = lzwfc_pkg::ST_IDLE;
                end
            end
            lzwfc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_sym  = i_symbol;
                    n_last = i_last;
                    if (!r_prefix_valid) begin
                        n_prefix       = CODE_BITS'(i_symbol);
                        n_prefix_valid = 1'b1;
                        if (i_last) begin
                            n_state = lzwfc_pkg::ST_FLUSH;
                        end
                    end else begin
                        n_slot  = w_prod[31 -: HASH_BITS];
                        n_state = lzwfc_pkg::ST_LOOK;
                    end
                end
            end
            lzwfc_pkg::ST_LOOK: begin
                n_state = lzwfc_pkg::ST_CMP;
            end
            lzwfc_pkg::ST_CMP: begin
                if (w_hit) begin
                    n_prefix = r_rd.code;
                    n_state  = r_last ? lzwfc_pkg::ST_FLUSH : lzwfc_pkg::ST_IDLE;
                end else if (w_live) begin
                    n_slot  = r_slot + HASH_BITS'(1);
                    n_state = lzwfc_pkg::ST_LOOK;
                end else begin
                    if (r_next_code < LIMIT_N) begin
                        w_we        = 1'b1;
                        w_wdata.gen = r_cur_gen;
                        w_wdata.key = w_key;
                        w_wdata.code = r_next_code[CODE_BITS-1:0];
                        n_next_code = r_next_code + NEXT_W'(1);
                    end
                    n_state = lzwfc_pkg::ST_EMIT;
                end
            end
            lzwfc_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_code  = lzwfc_pkg::CODE_W'(r_prefix);
                    n_o_last  = 1'b0;
                    n_prefix  = CODE_BITS'(r_sym);
                    n_state   = r_last ? lzwfc_pkg::ST_FLUSH : lzwfc_pkg::ST_IDLE;
                end
            end
            lzwfc_pkg::ST_FLUSH: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_code  = lzwfc_pkg::CODE_W'(r_prefix);
                    n_o_last  = 1'b0;
                    n_state   = lzwfc_pkg::ST_TERM;
                end
            end
            lzwfc_pkg::ST_TERM: begin
                if (w_out_free) begin
                    n_o_valid      = 1'b1;
                    n_o_code       = '0;
                    n_o_last       = 1'b1;
                    n_prefix_valid = 1'b0;
                    n_next_code    = FIRST_N;
                    if (r_cur_gen == '1) begin
                        n_cur_gen = lzwfc_pkg::EPOCH_W'(1);
                        n_state   = lzwfc_pkg::ST_CLEAR;
                    end else begin
                        n_cur_gen = r_cur_gen + lzwfc_pkg::EPOCH_W'(1);
                        n_state   = lzwfc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = lzwfc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= lzwfc_pkg::ST_CLEAR;
            r_clr_addr     <= '0;
            r_cur_gen      <= lzwfc_pkg::EPOCH_W'(1);
            r_next_code    <= FIRST_N;
            r_prefix_valid <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr_addr     <= n_clr_addr;
            r_cur_gen      <= n_cur_gen;
            r_next_code    <= n_next_code;
            r_prefix_valid <= n_prefix_valid;
            r_o_valid      <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prefix <= n_prefix;
        r_sym    <= n_sym;
        r_last   <= n_last;
        r_slot   <= n_slot;
        r_o_code <= n_o_code;
        r_o_last <= n_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_wdata;
        end
        r_rd <= mem[w_addr];
    end

`ifndef SYNTH
    a_term_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |-> (r_o_code == '0))
        else $error("terminator word carries a nonzero code");

    a_next_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_code >= FIRST_N) && (r_next_code <= LIMIT_N))
        else $error("next code outside its range");

    a_hit_code_learned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzwfc_pkg::ST_CMP && w_hit) |-> (NEXT_W'(r_rd.code) < r_next_code))
        else $error("table hit returned a code not yet assigned");
`endif

endmodule

[tb/tb.sv]
// Self-checking testbench for the LZW fixed-code compressor with a reference predictor.
`timescale 1ns / 1ps

module tb;

    localparam int SYM_W      = lzwfc_pkg::SYM_W;
    localparam int CODE_W     = lzwfc_pkg::CODE_W;
    localparam int FIRST_CODE = lzwfc_pkg::FIRST_CODE;

    localparam int TB_CODE_BITS = 10;
    localparam int TB_DICT_SIZE = 256;
    localparam int CODE_LIMIT   = (TB_DICT_SIZE < (1 << TB_CODE_BITS)) ?
                                  TB_DICT_SIZE : (1 << TB_CODE_BITS);
    localparam int IDLE_PCT     = 45;
    localparam int BOTH_PCT     = 28;
    localparam int HOLD_CYCLES  = 400;
    localparam int LONG_LEN     = 136;
    localparam int SHORT_TOTAL  = 8;
    localparam int DRAIN_CYCLES = 40;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        logic [SYM_W-1:0] sym;
        logic             last;
        t_idle_mode       mode;
        bit               hold;
    } t_sym_word;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic              last_code;
    } t_code_word;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_ready;
    logic [SYM_W-1:0]  i_symbol    = '0;
    logic              i_last      = 1'b0;
    logic              o_valid;
    logic              i_ready     = 1'b0;
    logic [CODE_W-1:0] o_code;
    logic              o_last_code;

    t_sym_word  sym_words[$];
    t_code_word exp_codes[$];

    bit [CODE_W-1:0] pair_dict[bit [CODE_W+SYM_W-1:0]];
    int              dict_next;
    logic [CODE_W-1:0] pfx_code;
    bit              pfx_valid;

    t_idle_mode cur_mode  = IDLE_NONE;
    logic       hold_req  = 1'b0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    int n_total;
    int n_accepted;
    int n_streams;
    int n_checked;
    int n_frozen_miss;
    int n_errors;

    lzw_fixed_code_compressor #(
        .CODE_BITS (TB_CODE_BITS),
        .DICT_SIZE (TB_DICT_SIZE)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_symbol    (i_symbol),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_code      (o_code),
        .o_last_code (o_last_code)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_pct(t_idle_mode m, bit rx);
        case (m)
            IDLE_SEND: return rx ? 0 : IDLE_PCT;
            IDLE_RECV: return rx ? IDLE_PCT : 0;
            IDLE_BOTH: return BOTH_PCT;
            default:   return 0;
        endcase
    endfunction

    function automatic void add_word(input logic [SYM_W-1:0] sym, input logic last,
                                     input t_idle_mode mode = IDLE_NONE,
                                     input bit hold = 1'b0);
        t_sym_word w;
        w.sym  = sym;
        w.last = last;
        w.mode = mode;
        w.hold = hold;
        sym_words.insert(sym_words.size(), w);
        n_total++;
    endfunction

    function automatic void push_code(input logic [CODE_W-1:0] code, input logic last_code);
        t_code_word c;
        c.code      = code;
        c.last_code = last_code;
        exp_codes.insert(exp_codes.size(), c);
    endfunction

    function automatic void lzw_predict(input logic [SYM_W-1:0] sym, input logic last);
        bit [CODE_W+SYM_W-1:0] key;
        if (!pfx_valid) begin
            pfx_code  = CODE_W'(sym);
            pfx_valid = 1'b1;
        end else begin
            key = {pfx_code, sym};
            if (pair_dict.exists(key)) begin
                pfx_code = pair_dict[key];
            end else begin
                push_code(pfx_code, 1'b0);
                if (dict_next < CODE_LIMIT) begin
                    pair_dict[key] = CODE_W'(dict_next);
                    dict_next++;
                end else begin
                    n_frozen_miss++;
                end
                pfx_code = CODE_W'(sym);
            end
        end
        if (last) begin
            push_code(pfx_code, 1'b0);
            push_code('0, 1'b1);
            pair_dict.delete();
            dict_next = FIRST_CODE;
            pfx_code  = '0;
            pfx_valid = 1'b0;
            n_streams++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_sym_word w;
        bit        fire;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            fire = i_valid && o_ready;
            if (fire) begin
                lzw_predict(i_symbol, i_last);
                n_accepted++;
            end
            if (fire || !i_valid) begin
                if (sym_words.size() > 0 &&
                    $urandom_range(99) >= idle_pct(sym_words[0].mode, 1'b0)) begin
                    w = sym_words.pop_front();
                    i_symbol <= w.sym;
                    i_last   <= w.last;
                    cur_mode <= w.mode;
                    if (w.hold) begin
                        hold_req <= 1'b1;
                    end
                    i_valid  <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_code_word want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (exp_codes.size() == 0) begin
                    $error("unexpected word: code %0d last_code %0b", o_code, o_last_code);
                    n_errors++;
                end else begin
                    want = exp_codes.pop_front();
                    n_checked++;
                    if (o_code !== want.code) begin
                        $error("code: expected %0d, got %0d", want.code, o_code);
                        n_errors++;
                    end
                    if (o_last_code !== want.last_code) begin
                        $error("last_code: expected %0b, got %0b", want.last_code,
                               o_last_code);
                        n_errors++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= idle_pct(cur_mode, 1'b1));
            end
        end
    end

    initial begin
        #2000000;
        $display("tb failed");
        $finish;
    end

    initial begin
        int         i;
        int         idx;
        int         len;
        int         base;
        int         short_cnt;
        t_idle_mode m;
        logic [SYM_W-1:0] s;

        dict_next = FIRST_CODE;
        pfx_code  = '0;
        pfx_valid = 1'b0;

        add_word(7'd127, 1'b1);
        add_word(7'd0, 1'b1);
        for (i = 0; i < 6; i++) add_word(7'd0, i == 5);
        for (i = 0; i < 7; i++) add_word((i % 2) ? 7'd0 : 7'd127, i == 6);
        for (i = 0; i < 5; i++) add_word((i % 2) ? 7'h2A : 7'h55, i == 4);
        add_word(7'd3, 1'b0);
        add_word(7'd3, 1'b0);
        add_word(7'd3, 1'b0);
        add_word(7'd3, 1'b0);
        add_word(7'd9, 1'b1);

        // long stream: mostly misses, runs the dictionary into its freeze
        idx = 0;
        for (i = 0; i < LONG_LEN; i++) begin
            m = t_idle_mode'((idx / 20) % 4);
            add_word(SYM_W'($urandom_range(0, 127)), i == LONG_LEN - 1, m, i == 10);
            idx++;
        end

        // short streams over narrow alphabets for deep prefixes
        short_cnt = 0;
        while (short_cnt < SHORT_TOTAL) begin
            len  = $urandom_range(1, 14);
            base = $urandom_range(0, 124);
            for (i = 0; i < len; i++) begin
                m = t_idle_mode'((idx / 20) % 4);
                if ($urandom_range(0, 9) == 0) begin
                    s = SYM_W'($urandom_range(0, 127));
                end else begin
                    s = SYM_W'(base + $urandom_range(0, 3));
                end
                add_word(s, i == len - 1, m);
                idx++;
            end
            short_cnt += len;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total) @(negedge i_clk);
        while (exp_codes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d symbols in %0d streams, %0d code words checked, %0d errors",
                 n_accepted, n_streams, n_checked, n_errors);
        $display("%0d misses after the dictionary froze; idle phases and a %0d-cycle hold-off",
                 n_frozen_miss, HOLD_CYCLES);
        if (n_errors == 0 && exp_codes.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/lzwfc_pkg.sv
src/lzw_fixed_code_compressor.sv
tb/tb.sv
